// File: design/door_contact_monitor_defines.svh
// Assertion macros for the door contact monitor.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DOOR_CONTACT_MONITOR_DEFINES_SVH
`define DOOR_CONTACT_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define DCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dcm_pkg.sv
// Shared types and constants for the door contact monitor.
// No dependencies; imported by every module of the block.
package dcm_pkg;

  // Default widths
  localparam int unsigned TIME_WIDTH_DEF       = 32;
  localparam int unsigned HELD_COUNT_WIDTH_DEF = 8;

  // Configuration register widths and port widths
  localparam int unsigned MS_WIDTH     = 16;
  localparam int unsigned LIMIT_WIDTH  = 8;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HELD_PERIOD_MS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HELD_LIMIT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER_MS      = 8'd3;

  // Reset values of the configuration registers
  localparam logic [MS_WIDTH-1:0]    DEBOUNCE_MS_RST    = 16'd100;
  localparam logic [MS_WIDTH-1:0]    HELD_PERIOD_MS_RST = 16'd1000;
  localparam logic [LIMIT_WIDTH-1:0] HELD_LIMIT_RST     = 8'd20;
  localparam logic [MS_WIDTH-1:0]    BUZZER_MS_RST      = 16'd1000;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_OPENED = 2'd1,
    EV_CLOSED = 2'd2,
    EV_HELD   = 2'd3
  } event_t;

  // One result item
  typedef struct packed {
    logic   door_level;
    logic   buzzer_level;
    event_t event_code;
  } result_t;

  // Status of the result buffer toward the top level
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_status_t;

endpackage

// File: design/dcm_core.sv
// Tick update logic and state registers of the door contact monitor.
// Depends on dcm_pkg; feeds one result per accepted tick to the buffer.
module dcm_core
  import dcm_pkg::*;
#(
  parameter int unsigned TIME_WIDTH       = TIME_WIDTH_DEF,
  parameter int unsigned HELD_COUNT_WIDTH = HELD_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_fire,
  input  logic                  contact_level,
  input  logic                  cfg_fire,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  localparam int unsigned CMP_W = (HELD_COUNT_WIDTH > LIMIT_WIDTH) ?
                                  HELD_COUNT_WIDTH : LIMIT_WIDTH;

  // Configuration registers
  logic [MS_WIDTH-1:0]    debounce_ms_r;
  logic [MS_WIDTH-1:0]    held_period_ms_r;
  logic [LIMIT_WIDTH-1:0] held_limit_r;
  logic [MS_WIDTH-1:0]    buzzer_ms_r;

  // Tick state
  logic [TIME_WIDTH-1:0]       time_now_r, time_now_nxt;
  logic                        last_raw_r, last_raw_nxt;
  logic                        stable_r, stable_nxt;
  logic [TIME_WIDTH-1:0]       raw_change_r, raw_change_nxt;
  logic [TIME_WIDTH-1:0]       held_mark_r, held_mark_nxt;
  logic [HELD_COUNT_WIDTH-1:0] held_count_r, held_count_nxt;
  logic                        held_reported_r, held_reported_nxt;
  logic                        buzzer_r, buzzer_nxt;
  logic [TIME_WIDTH-1:0]       buzzer_start_r, buzzer_start_nxt;

  logic [TIME_WIDTH-1:0] debounce_elapsed;
  logic [TIME_WIDTH-1:0] held_elapsed;
  logic [TIME_WIDTH-1:0] buzzer_elapsed;
  logic                  stable_window;
  logic                  opening;
  logic                  buzzer_due;
  logic                  period_due;
  event_t                ev;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r    <= DEBOUNCE_MS_RST;
      held_period_ms_r <= HELD_PERIOD_MS_RST;
      held_limit_r     <= HELD_LIMIT_RST;
      buzzer_ms_r      <= BUZZER_MS_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:    debounce_ms_r    <= cfg_data;
        REG_HELD_PERIOD_MS: held_period_ms_r <= cfg_data;
        REG_HELD_LIMIT:     held_limit_r     <= cfg_data[LIMIT_WIDTH-1:0];
        REG_BUZZER_MS:      buzzer_ms_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compute the state after one tick and its result
  always_comb begin
    time_now_nxt      = time_now_r + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
    last_raw_nxt      = contact_level;
    raw_change_nxt    = (contact_level != last_raw_r) ? time_now_nxt : raw_change_r;
    stable_nxt        = stable_r;
    held_mark_nxt     = held_mark_r;
    held_count_nxt    = held_count_r;
    held_reported_nxt = held_reported_r;
    buzzer_nxt        = buzzer_r;
    buzzer_start_nxt  = buzzer_start_r;
    ev                = EV_NONE;

    debounce_elapsed = time_now_nxt - raw_change_nxt;
    held_elapsed     = time_now_nxt - held_mark_r;
    buzzer_elapsed   = time_now_nxt - buzzer_start_r;

    stable_window = debounce_elapsed >= {{(TIME_WIDTH-MS_WIDTH){1'b0}}, debounce_ms_r};
    period_due    = held_elapsed >= {{(TIME_WIDTH-MS_WIDTH){1'b0}}, held_period_ms_r};
    opening       = stable_window && (stable_r != contact_level) && contact_level;

    // An opening restarts the buzzer, so its elapsed time is zero
    buzzer_due = opening ? (buzzer_ms_r == '0) :
                 (buzzer_elapsed >= {{(TIME_WIDTH-MS_WIDTH){1'b0}}, buzzer_ms_r});

    if (stable_window) begin
      if (stable_r != contact_level) begin
        stable_nxt = contact_level;
        if (contact_level) begin
          buzzer_nxt       = 1'b1;
          buzzer_start_nxt = time_now_nxt;
          ev               = EV_OPENED;
        end else begin
          ev = EV_CLOSED;
        end
      end else if (stable_r) begin
        // Advance the held counter once per period, saturating
        if (period_due) begin
          if (!(&held_count_r)) begin
            held_count_nxt = held_count_r + {{(HELD_COUNT_WIDTH-1){1'b0}}, 1'b1};
          end
          held_mark_nxt = time_now_nxt;
        end
        if ((CMP_W'(held_count_nxt) == CMP_W'(held_limit_r)) && !held_reported_r) begin
          held_reported_nxt = 1'b1;
          ev                = EV_HELD;
        end
      end else begin
        held_count_nxt    = '0;
        held_reported_nxt = 1'b0;
      end
      // Drop the buzzer once its on time has run out
      if (buzzer_nxt && buzzer_due) begin
        buzzer_nxt = 1'b0;
      end
    end

    result.event_code   = ev;
    result.buzzer_level = buzzer_nxt;
    result.door_level   = stable_nxt;
  end

  // Hold tick state, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r      <= '0;
      last_raw_r      <= 1'b1;
      stable_r        <= 1'b1;
      raw_change_r    <= '0;
      held_mark_r     <= '0;
      held_count_r    <= '0;
      held_reported_r <= 1'b0;
      buzzer_r        <= 1'b0;
      buzzer_start_r  <= '0;
    end else if (tick_fire) begin
      time_now_r      <= time_now_nxt;
      last_raw_r      <= last_raw_nxt;
      stable_r        <= stable_nxt;
      raw_change_r    <= raw_change_nxt;
      held_mark_r     <= held_mark_nxt;
      held_count_r    <= held_count_nxt;
      held_reported_r <= held_reported_nxt;
      buzzer_r        <= buzzer_nxt;
      buzzer_start_r  <= buzzer_start_nxt;
    end
  end

endmodule

// File: design/dcm_out_buf.sv
// Result register with a skid stage for the door contact monitor.
// Depends on dcm_pkg; parts the tick side from a stalling receiver.
module dcm_out_buf
  import dcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  result_t     push_data,
  output logic        push_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  output buf_status_t status
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  // Refill the output register from the skid stage first, else park in skid
  always_comb begin
    pop            = out_valid_r && out_ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || pop) begin
      out_nxt        = skid_valid_r ? skid_r : push_data;
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign push_ready       = !skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign status.out_full  = out_valid_r;
  assign status.skid_full = skid_valid_r;

endmodule

// File: design/door_contact_monitor.sv
// Door contact monitor: each input request is one millisecond tick with the
// raw contact level; each tick yields one result with event code, buzzer
// drive and debounced door level.
// Input channel in_*: tdata bit 0 is the contact level (1 open).
// Output channel out_*: tdata bits 1:0 event code (0 none, 1 opened,
// 2 closed, 3 held), bit 2 buzzer level, bit 3 debounced door level.
// Configuration channel cfg_*: index 0 debounce, 1 held period, 2 held
// limit, 3 buzzer time; other indexes are ignored. cfg_ready is always high.
// Each result is registered in the result register, or in the skid stage
// while the receiver stalls. One tick per cycle while in_tready is high, set
// by the combinational state update between state and result registers.
// A result register plus a skid stage let one more tick in while the
// receiver stalls; with both full, in_tready drops until a result leaves.
// Reset (rst_n low, synchronous) loads the default register values, clears
// the time base, treats the door as open and idle, and empties the buffer.
// Depends on dcm_pkg, dcm_core, dcm_out_buf and the assertion macro header.
`include "door_contact_monitor_defines.svh"

module door_contact_monitor
  import dcm_pkg::*;
#(
  parameter int unsigned TIME_WIDTH       = TIME_WIDTH_DEF,
  parameter int unsigned HELD_COUNT_WIDTH = HELD_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Tick input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] contact_level, [7:1] zero
  // Results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] event_code, [2] buzzer_level,
                                             // [3] door_level, [7:4] zero
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic        tick_fire;
  logic        cfg_fire;
  result_t     tick_result;
  result_t     out_data;
  buf_status_t buf_status;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign tick_fire = in_tvalid && in_tready;

  // Update state per tick
  dcm_core #(
    .TIME_WIDTH       (TIME_WIDTH),
    .HELD_COUNT_WIDTH (HELD_COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_fire     (tick_fire),
    .contact_level (in_tdata[0]),
    .cfg_fire      (cfg_fire),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result        (tick_result)
  );

  // Hold results for the receiver
  dcm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tick_fire),
    .push_data  (tick_result),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data),
    .status     (buf_status)
  );

  assign out_tdata = {{(OUT_TDATA_W-4){1'b0}}, out_data};

  // Skid stage only fills behind a full result register
  `DCM_ASSERT_NOW(a_skid_behind_out, buf_status.skid_full, buf_status.out_full,
                  "skid stage full while result register empty")

  // An opening always leaves the door open, a closing leaves it closed
  `DCM_ASSERT_NOW(a_open_level, out_tvalid && (out_data.event_code == EV_OPENED),
                  out_data.door_level, "opened event with door closed")
  `DCM_ASSERT_NOW(a_close_level, out_tvalid && (out_data.event_code == EV_CLOSED),
                  !out_data.door_level, "closed event with door open")

  // Held is only reported while the door is open
  `DCM_ASSERT_NOW(a_held_open, out_tvalid && (out_data.event_code == EV_HELD),
                  out_data.door_level, "held event with door closed")

  // A tick accepted into an empty buffer shows up on the next cycle
  `DCM_ASSERT_NEXT(a_tick_latency, tick_fire && !buf_status.out_full, out_tvalid,
                   "accepted tick not presented")

endmodule
